>>> src/wcpc_pkg.sv
// Shared types and constants of the window and cursor pixel compositor.
// Used by the compositor top level and its port checker; depends on nothing.
`timescale 1ns / 1ps

package wcpc_pkg;

	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 136;
	localparam int PIX_W      = 32;
	localparam int BOUND_W    = 18;

	localparam logic [PIX_W-1:0] BACKGROUND_COLOR = 32'h0020_4060;
	localparam logic [PIX_W-1:0] BORDER_COLOR     = 32'h00ff_ffff;
	localparam logic signed [BOUND_W-1:0] BORDER_SIZE = 18'sd3;
	localparam logic [15:0] ROUND_BIAS = 16'd127;
	localparam logic [7:0]  ALPHA_FULL = 8'hff;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WIN_WR = 2'd0,
		FUNC_SPR_WR = 2'd1,
		FUNC_RENDER = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCUS    = 3'd0,
		CFG_CUR_LEFT = 3'd1,
		CFG_CUR_TOP  = 3'd2,
		CFG_CUR_WIDE = 3'd3,
		CFG_CUR_TALL = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MIX_KEEP  = 2'd0,
		MIX_COPY  = 2'd1,
		MIX_BLEND = 2'd2
	} mix_t;

	// Window bounds kept in the form the pixel test needs: outer and inner edges.
	typedef struct packed {
		logic signed [BOUND_W-1:0] lo_x;
		logic signed [BOUND_W-1:0] hi_x;
		logic signed [BOUND_W-1:0] lo_y;
		logic signed [BOUND_W-1:0] hi_y;
		logic signed [BOUND_W-1:0] in_lo_x;
		logic signed [BOUND_W-1:0] in_hi_x;
		logic signed [BOUND_W-1:0] in_lo_y;
		logic signed [BOUND_W-1:0] in_hi_y;
	} win_rect_t;

endpackage

>>> src/wcpc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; used for the cursor sprite store.
`timescale 1ns / 1ps

module wcpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/window_cursor_pixel_compositor_unit.sv
// Window and cursor pixel compositor: six-stage pixel pipeline with window table.
// Depends on wcpc_pkg and wcpc_ram.
`timescale 1ns / 1ps

// Usage
// The slave side takes one beat per item: tuser carries the function (window slot
// write, cursor sprite word write or render), tdata the fields. A render beat gives
// one composited xRGB pixel on the master side; write beats give no output beat.
// The configuration port sets the focused slot and the cursor position and size;
// the user uses it only while no render is in flight; the block does not enforce it.
// Throughput is one beat per cycle while s_tready is high. A render result passes
// the input register, window test, sprite address, sprite RAM read, blend products
// and rounded divide stages before it can be taken. The sprite RAM takes a sprite
// write or a render read, on its write or read port, at the third stage.
// Reset empties the window table, clears the focus and hides the cursor. The sprite
// RAM is not cleared; an entry reads back correctly once it has been written.
// When the receiver stalls, the pipeline closes up its bubbles and keeps taking
// beats; s_tready falls only when every stage holds a beat.

module window_cursor_pixel_compositor_unit #(
	parameter int WINDOW_SLOTS = 4,
	parameter int CURSOR_SIDE  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input beat.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata from bit 0: px, py, slot, rect_left, rect_top, rect_width, rect_height,
	// color_word, cursor_index, zero padding.
	input  logic [wcpc_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: func.
	input  logic [wcpc_pkg::FUNC_W-1:0]        s_tuser,
	// Output beat.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata: pixel_out.
	output logic [wcpc_pkg::PIX_W-1:0]         m_tdata,
	// Configuration writes.
	input  logic                               cfg_we,
	input  logic [wcpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [wcpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SLOT_IW      = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int SPRITE_WORDS = CURSOR_SIDE * CURSOR_SIDE;
	localparam int ADDR_W       = $clog2(SPRITE_WORDS);
	localparam logic [5:0] SIDE_CLAMP = 6'((CURSOR_SIDE > 63) ? 63 : CURSOR_SIDE);

	// Configuration registers.
	logic [2:0]  focus_q;
	logic [15:0] cur_left_q;
	logic [15:0] cur_top_q;
	logic [5:0]  cur_wide_q;
	logic [5:0]  cur_tall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_q    <= 3'b111;
			cur_left_q <= '0;
			cur_top_q  <= '0;
			cur_wide_q <= '0;
			cur_tall_q <= '0;
		end else if (cfg_we) begin
			case (wcpc_pkg::cfg_reg_t'(cfg_idx))
				wcpc_pkg::CFG_FOCUS:    focus_q    <= cfg_data[2:0];
				wcpc_pkg::CFG_CUR_LEFT: cur_left_q <= cfg_data;
				wcpc_pkg::CFG_CUR_TOP:  cur_top_q  <= cfg_data;
				wcpc_pkg::CFG_CUR_WIDE: cur_wide_q <= cfg_data[5:0];
				wcpc_pkg::CFG_CUR_TALL: cur_tall_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and the ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || m_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// Stage 1: input register.
	wcpc_pkg::func_t func_s1;
	logic [11:0] px_s1, py_s1;
	logic [1:0]  slot_s1;
	logic [15:0] rl_s1, rt_s1;
	logic [14:0] rw_s1, rh_s1;
	logic [31:0] color_s1;
	logic [9:0]  idx_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			func_s1  <= wcpc_pkg::func_t'(s_tuser);
			px_s1    <= s_tdata[11:0];
			py_s1    <= s_tdata[23:12];
			slot_s1  <= s_tdata[25:24];
			rl_s1    <= s_tdata[41:26];
			rt_s1    <= s_tdata[57:42];
			rw_s1    <= s_tdata[72:58];
			rh_s1    <= s_tdata[87:73];
			color_s1 <= s_tdata[119:88];
			idx_s1   <= s_tdata[129:120];
		end
	end

	// Window table, written as a slot write leaves stage 1.
	wcpc_pkg::win_rect_t win_q [WINDOW_SLOTS];
	logic [31:0]         wcol_q [WINDOW_SLOTS];
	wcpc_pkg::win_rect_t new_rect;
	logic                win_wr;

	always_comb begin
		new_rect.lo_x    = {{2{rl_s1[15]}}, rl_s1};
		new_rect.lo_y    = {{2{rt_s1[15]}}, rt_s1};
		new_rect.hi_x    = new_rect.lo_x + {3'b000, rw_s1};
		new_rect.hi_y    = new_rect.lo_y + {3'b000, rh_s1};
		new_rect.in_lo_x = new_rect.lo_x + wcpc_pkg::BORDER_SIZE;
		new_rect.in_lo_y = new_rect.lo_y + wcpc_pkg::BORDER_SIZE;
		new_rect.in_hi_x = new_rect.hi_x - wcpc_pkg::BORDER_SIZE;
		new_rect.in_hi_y = new_rect.hi_y - wcpc_pkg::BORDER_SIZE;
	end

	assign win_wr = v_s1 && rdy2 && (func_s1 == wcpc_pkg::FUNC_WIN_WR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SLOTS; i++) begin
				win_q[i]  <= '0;
				wcol_q[i] <= '0;
			end
		end else if (win_wr) begin
			for (int i = 0; i < WINDOW_SLOTS; i++) begin
				if (int'(slot_s1) == i) begin
					win_q[i]  <= new_rect;
					wcol_q[i] <= color_s1;
				end
			end
		end
	end

	// Window test and cursor placement for a render in stage 1.
	logic signed [17:0] x18, y18, cur_l18, cur_t18, cx18, cy18, w18, h18;
	logic [5:0]  w_clamp, h_clamp;
	logic [WINDOW_SLOTS-1:0] win_cover, rim;
	logic        win_hit, win_border;
	logic [SLOT_IW-1:0] win_idx;
	logic [31:0] win_pix;
	logic        cur_hit;

	assign x18     = signed'({6'b000000, px_s1});
	assign y18     = signed'({6'b000000, py_s1});
	assign cur_l18 = signed'({{2{cur_left_q[15]}}, cur_left_q});
	assign cur_t18 = signed'({{2{cur_top_q[15]}}, cur_top_q});
	assign cx18    = x18 - cur_l18;
	assign cy18    = y18 - cur_t18;
	assign w_clamp = (cur_wide_q > SIDE_CLAMP) ? SIDE_CLAMP : cur_wide_q;
	assign h_clamp = (cur_tall_q > SIDE_CLAMP) ? SIDE_CLAMP : cur_tall_q;
	assign w18     = signed'({12'b0, w_clamp});
	assign h18     = signed'({12'b0, h_clamp});
	assign cur_hit = !cx18[17] && !cy18[17] && (cx18 < w18) && (cy18 < h18);

	always_comb begin
		win_hit    = 1'b0;
		win_border = 1'b0;
		win_idx    = '0;
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			win_cover[i] = (x18 >= win_q[i].lo_x) && (x18 < win_q[i].hi_x) &&
			               (y18 >= win_q[i].lo_y) && (y18 < win_q[i].hi_y);
			rim[i]       = (x18 < win_q[i].in_lo_x) || (y18 < win_q[i].in_lo_y) ||
			               (x18 >= win_q[i].in_hi_x) || (y18 >= win_q[i].in_hi_y);
			// Later slots lie on top, so the last covering slot decides.
			if (win_cover[i]) begin
				win_hit    = 1'b1;
				win_idx    = SLOT_IW'(i);
				win_border = rim[i] && !focus_q[2] && (int'(focus_q[1:0]) == i);
			end
		end
		if (!win_hit) begin
			win_pix = wcpc_pkg::BACKGROUND_COLOR;
		end else if (win_border) begin
			win_pix = wcpc_pkg::BORDER_COLOR;
		end else begin
			win_pix = wcol_q[win_idx];
		end
	end

	// Stage 2: window pixel and cursor offsets.
	wcpc_pkg::func_t func_s2;
	logic [31:0] pix_s2, color_s2;
	logic        cur_s2;
	logic [5:0]  cx_s2, cy_s2, w_s2;
	logic [9:0]  idx_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			func_s2  <= func_s1;
			pix_s2   <= win_pix;
			cur_s2   <= cur_hit;
			cx_s2    <= cx18[5:0];
			cy_s2    <= cy18[5:0];
			w_s2     <= w_clamp;
			color_s2 <= color_s1;
			idx_s2   <= idx_s1;
		end
	end

	// Sprite address: row times clamped width plus column.
	logic [11:0] row_base, addr_full;
	logic [ADDR_W-1:0] addr_next;
	logic        wok_next;

	assign row_base  = cy_s2 * w_s2;
	assign addr_full = row_base + {6'b000000, cx_s2};
	assign wok_next  = int'(idx_s2) < SPRITE_WORDS;
	assign addr_next = (func_s2 == wcpc_pkg::FUNC_SPR_WR) ? ADDR_W'(idx_s2)
	                                                      : addr_full[ADDR_W-1:0];

	// Stage 3: sprite RAM access.
	wcpc_pkg::func_t func_s3;
	logic [31:0] pix_s3, color_s3;
	logic        cur_s3, wok_s3;
	logic [ADDR_W-1:0] addr_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			func_s3  <= func_s2;
			pix_s3   <= pix_s2;
			cur_s3   <= cur_s2;
			color_s3 <= color_s2;
			wok_s3   <= wok_next;
			addr_s3  <= addr_next;
		end
	end

	logic        spr_we;
	logic [31:0] fg_s4;

	assign spr_we = v_s3 && rdy4 && (func_s3 == wcpc_pkg::FUNC_SPR_WR) && wok_s3;

	// The read register doubles as the stage 4 sprite word and holds while stage 4 waits.
	wcpc_ram #(
		.WIDTH(wcpc_pkg::PIX_W),
		.DEPTH(SPRITE_WORDS)
	) u_sprite_ram (
		.clk   (clk),
		.we    (spr_we),
		.waddr (addr_s3),
		.wdata (color_s3),
		.re    (rdy4),
		.raddr (addr_s3),
		.rdata (fg_s4)
	);

	// Stage 4: sprite word, window pixel.
	logic [31:0] pix_s4;
	logic        cur_s4;

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			pix_s4 <= pix_s3;
			cur_s4 <= cur_s3;
		end
	end

	logic [7:0]  alpha, alpha_inv;
	logic [2:0][15:0] mix_sum;
	wcpc_pkg::mix_t mix_next;

	assign alpha     = fg_s4[31:24];
	assign alpha_inv = wcpc_pkg::ALPHA_FULL - alpha;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix_sum[c] = (fg_s4[8*c +: 8] * alpha) + (pix_s4[8*c +: 8] * alpha_inv) +
			             wcpc_pkg::ROUND_BIAS;
		end
		if (!cur_s4 || (alpha == 8'h00)) begin
			mix_next = wcpc_pkg::MIX_KEEP;
		end else if (alpha == wcpc_pkg::ALPHA_FULL) begin
			mix_next = wcpc_pkg::MIX_COPY;
		end else begin
			mix_next = wcpc_pkg::MIX_BLEND;
		end
	end

	// Stage 5: channel sums before the divide by 255.
	wcpc_pkg::mix_t   mix_s5;
	logic [31:0]      pix_s5;
	logic [23:0]      fg_s5;
	logic [2:0][15:0] sum_s5;

	always_ff @(posedge clk) begin
		if (v_s4 && rdy5) begin
			mix_s5 <= mix_next;
			pix_s5 <= pix_s4;
			fg_s5  <= fg_s4[23:0];
			sum_s5 <= mix_sum;
		end
	end

	// n / 255 as (n + 1 + n / 256) / 256, exact for n up to 65534, above every sum here.
	logic [2:0][16:0] quot_sum;
	logic [23:0]      blend_rgb;
	logic [31:0]      pix_next;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			quot_sum[c] = {1'b0, sum_s5[c]} + 17'd1 + {9'b0, sum_s5[c][15:8]};
			blend_rgb[8*c +: 8] = quot_sum[c][15:8];
		end
		case (mix_s5)
			wcpc_pkg::MIX_KEEP:  pix_next = pix_s5;
			wcpc_pkg::MIX_COPY:  pix_next = {8'h00, fg_s5};
			wcpc_pkg::MIX_BLEND: pix_next = {8'h00, blend_rgb};
			default:             pix_next = pix_s5;
		endcase
	end

	// Stage 6: output register.
	always_ff @(posedge clk) begin
		if (v_s5 && rdy6) begin
			m_tdata <= pix_next;
		end
	end

	assign m_tvalid = v_s6;

	// Write beats drop out once their table or RAM write is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1 && ((func_s1 == wcpc_pkg::FUNC_RENDER) ||
				                 (func_s1 == wcpc_pkg::FUNC_SPR_WR));
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3 && (func_s3 == wcpc_pkg::FUNC_RENDER);
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
			if (rdy6) begin
				v_s6 <= v_s5;
			end
		end
	end

endmodule

>>> src/wcpc_checker.sv
// Port checker for the compositor: back-pressure, stall and latency properties.
// Depends on wcpc_pkg; bound to window_cursor_pixel_compositor_unit below.
`timescale 1ns / 1ps

module wcpc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [wcpc_pkg::FUNC_W-1:0]    s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wcpc_pkg::PIX_W-1:0]     m_tdata
);

	// A waiting output beat keeps its pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("output beat changed while stalled");

	// The input side only pushes back while the receiver holds off a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
	else $error("input stalled without output back-pressure");

	// With the receiver always ready, an accepted render beat must reach the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == wcpc_pkg::FUNC_RENDER) && m_tready
		 ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready)
		|-> ##1 m_tvalid)
	else $error("render result missing after pipeline latency");

endmodule

bind window_cursor_pixel_compositor_unit wcpc_checker u_wcpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
